// ----- sv/s1b64_pkg.sv -----
`default_nettype none
package s1b64_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [6:0] b64_char;
    logic       last_char;
  } out_item_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenStart = 6'd56;
  localparam int unsigned DigestChars = 28;
  localparam logic [6:0]  PadChar = 7'h3D;

  // request from the byte front end to the compression core
  typedef struct packed {
    logic start;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  // round constant for a round index
  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) return 32'h5A827999;
    else if (r < 7'd40) return 32'h6ED9EBA1;
    else if (r < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

  // round function for a round index
  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) return (b & c) | (~b & d);
    else if (r < 7'd40) return b ^ c ^ d;
    else if (r < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction

  // six bit value to ascii base64 character
  function automatic logic [6:0] b64_map(input logic [5:0] v);
    if (v < 6'd26) return 7'(7'd65 + 7'(v));
    else if (v < 6'd52) return 7'(7'd97 + 7'(v) - 7'd26);
    else if (v < 6'd62) return 7'(7'd48 + 7'(v) - 7'd52);
    else if (v == 6'd62) return 7'h2B;
    else return 7'h2F;
  endfunction

endpackage
`default_nettype wire

// ----- sv/s1b64_core.sv -----
`default_nettype none
module s1b64_core (
  input  wire logic        clk,
  input  wire logic        wr_en,
  input  wire logic [5:0]  wr_addr,
  input  wire logic [7:0]  wr_byte,
  input  wire logic [3:0]  rd_addr,
  output logic [31:0]      rd_word
);

  // block store as 16 big-endian words, one byte lane written per transfer
  logic [31:0] mem [16];

  // byte write and registered word read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    rd_word <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- sv/s1b64_rounds.sv -----
`default_nettype none
module s1b64_rounds (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire s1b64_pkg::core_req_t  req,
  input  wire logic                  chain_init,
  input  wire logic                  load,
  input  wire logic [31:0]           load_word,
  output s1b64_pkg::core_stat_t      stat,
  output logic [159:0]               chain
);
  import s1b64_pkg::*;

  typedef enum logic [1:0] {IDLE, ROUND, ADD} state_t;

  state_t       state;
  logic [6:0]   rnd;
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  h [5];
  logic [31:0]  w_x, w_cur, t;
  logic         done;

  // schedule expansion and round sum
  always_comb begin
    w_x = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_cur = (rnd < 7'd16) ? w[0] : {w_x[30:0], w_x[31]};
    t = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w_cur;
  end

  assign chain = {h[0], h[1], h[2], h[3], h[4]};
  assign stat = {(state != IDLE), done};

  // window: shifts on load and on every round
  always_ff @(posedge clk) begin
    if (state == ROUND || (state == IDLE && load)) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= (state == ROUND) ? w_cur : load_word;
    end
  end

  // sequencer and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      rnd <= '0;
      done <= 1'b0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (chain_init) begin
            h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
          end
          if (req.start) begin
            state <= ROUND;
            rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          end
        end
        ROUND: begin
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= ADD;
        end
        ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  rounds_stay_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ROUND && rnd != 7'd79) |=> state == ROUND)
    else $error("round sequence broke early");
  done_after_add: assert property (@(posedge clk) disable iff (rst)
    (state == ADD) |=> stat.done)
    else $error("missing done after chain add");
  no_start_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !stat.busy)
    else $error("done while busy");

endmodule
`default_nettype wire

// ----- sv/sha1_digest_base64_top.sv -----
`default_nettype none
// sha1 digest with base64 output
// input channel (in_valid/in_ready/in_data): one message byte per transfer,
// byte_present marks a real byte, end_of_message closes the message.
// output channel (out_valid/out_ready/out_data): 28 base64 characters of the
// digest, the last one '=' with last_char set.
// a byte is taken while in_ready is high; the 64th byte of a block holds
// in_ready low through 16 word loads, a start, 80 rounds, the chain add and
// a done pulse.
// an end of message adds padding bytes at one per cycle up to the end of the
// block, one or two compressions, then 28 characters, one per cycle while
// out_ready is high. the input is not ready while characters are being sent.
// the output register holds its character while out_ready is low, and the
// sequencer waits for it.
// reset (rst, synchronous) returns to the initial hash words and an empty
// message; no clearing pass is needed.
module sha1_digest_base64_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire s1b64_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output s1b64_pkg::out_item_t      out_data
);
  import s1b64_pkg::*;

  typedef enum logic [2:0] {ACCEPT, PAD, LOAD, WAIT, EMIT} state_t;

  state_t        state;
  logic [5:0]    fill;
  logic [63:0]   bit_count;
  logic [63:0]   len;
  logic          finishing;
  logic          after_len;
  logic          len_ok;
  logic          len_done;
  logic [3:0]    word_idx;
  logic [31:0]   load_word;
  logic [4:0]    char_idx;
  logic [159:0]  digest;
  core_req_t     req;
  core_stat_t    stat;
  logic [159:0]  chain;
  logic          load;
  logic          chain_init;
  logic [7:0]    pad_byte;
  logic          wr_en;
  logic [7:0]    wr_byte;
  logic [5:0]    six;

  // padding byte for the current fill position
  always_comb begin
    if (after_len) pad_byte = PadByte;
    else if (len_ok && fill >= LenStart) pad_byte = 8'(len >> {fill[2:0] ^ 3'd7, 3'b000});
    else pad_byte = 8'h00;
  end

  // byte store write port
  always_comb begin
    wr_en = (state == PAD) || (state == ACCEPT && in_valid && in_data.byte_present);
    wr_byte = (state == PAD) ? pad_byte : in_data.data_byte;
  end

  // digest character select
  always_comb begin
    six = digest[159:154];
  end

  assign in_ready = (state == ACCEPT);

  // sequencer
  always_ff @(posedge clk) begin
    req.start <= 1'b0;
    load <= 1'b0;
    chain_init <= 1'b0;
    if (rst) begin
      state <= ACCEPT;
      fill <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      after_len <= 1'b0;
      len_ok <= 1'b0;
      len_done <= 1'b0;
      word_idx <= '0;
      char_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ACCEPT: begin
          if (in_valid) begin
            if (in_data.byte_present) begin
              bit_count <= bit_count + 64'd8;
              fill <= fill + 6'd1;
            end
            if (in_data.end_of_message) begin
              finishing <= 1'b1;
              after_len <= 1'b1;
              len <= bit_count + (in_data.byte_present ? 64'd8 : 64'd0);
            end
            if (in_data.byte_present && fill == 6'd63) begin
              state <= LOAD;
              word_idx <= '0;
            end else if (in_data.end_of_message) begin
              state <= PAD;
            end
          end
        end
        PAD: begin
          // the length fits in this block only if the 0x80 mark lands before it
          after_len <= 1'b0;
          if (after_len) len_ok <= (fill < LenStart);
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= LOAD;
            word_idx <= '0;
            if (!after_len && len_ok) begin
              finishing <= 1'b0;
              len_done <= 1'b1;
            end
          end
        end
        LOAD: begin
          load <= 1'b1;
          word_idx <= word_idx + 4'd1;
          if (word_idx == 4'd15) begin
            state <= WAIT;
            req.start <= 1'b1;
          end
        end
        WAIT: begin
          if (stat.done) begin
            if (len_done) begin
              state <= EMIT;
              len_done <= 1'b0;
              digest <= chain;
              char_idx <= '0;
              chain_init <= 1'b1;
              bit_count <= '0;
            end else if (finishing) begin
              state <= PAD;
              len_ok <= 1'b1;
            end else state <= ACCEPT;
          end
        end
        EMIT: begin
          if (!out_valid || out_ready) begin
            if (char_idx == 5'(DigestChars)) begin
              out_valid <= 1'b0;
              state <= ACCEPT;
            end else begin
              out_valid <= 1'b1;
              out_data.last_char <= (char_idx == 5'(DigestChars - 1));
              out_data.b64_char <= (char_idx == 5'(DigestChars - 1)) ? PadChar
                                 : b64_map(six);
              digest <= {digest[153:0], 6'd0};
              char_idx <= char_idx + 5'd1;
            end
          end
        end
        default: state <= ACCEPT;
      endcase
    end
  end

  s1b64_core u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill),
    .wr_byte (wr_byte),
    .rd_addr (word_idx),
    .rd_word (load_word)
  );

  s1b64_rounds u_rounds (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .chain_init (chain_init),
    .load       (load),
    .load_word  (load_word),
    .stat       (stat),
    .chain      (chain)
  );

  no_input_while_emit: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> !in_ready)
    else $error("input ready during emit");
  last_is_pad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last_char) |-> out_data.b64_char == PadChar)
    else $error("last character not pad");
  out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output dropped under stall");

endmodule
`default_nettype wire
